@@ rtl/note_record_decoder_defines.svh @@
// Assertion macros for the note record decoder.
// No dependencies; taken in by the modules that carry assertions.
`ifndef NOTE_RECORD_DECODER_DEFINES_SVH
`define NOTE_RECORD_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrd assertion failed");
// next-cycle implication
`define NRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nrd assertion failed");
`else
`define NRD_ASSERT_NOW(label, ante, cons)
`define NRD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/nrd_pkg.sv @@
// Shared types and constants of the note record decoder.
// No dependencies.
package nrd_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int TRACK_W    = $clog2(MAX_TRACKS);
    localparam int NT_W       = 5;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int DIV_STEPS  = BYTE_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;

    localparam logic [BYTE_W-1:0] VEL_DEFAULT = 8'd127;
    localparam logic [WORD_W-1:0] IDX_FULL    = 16'hFFFF;

    localparam logic [1:0] OUT_REST = 2'd0;
    localparam logic [1:0] OUT_OMIT = 2'd1;
    localparam logic [1:0] OUT_NOTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRACKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTS_EN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OMIT_SEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MSK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MSK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MSK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MSK = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_ONSET,
        S_OFFSET,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic read;
        logic onset;
        logic offset;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

@@ rtl/nrd_ctrl.sv @@
// Controller of the note record decoder: sequences divide, read, add and commit.
// Depends on nrd_pkg and note_record_decoder_defines.svh.
`include "note_record_decoder_defines.svh"
module nrd_ctrl
    import nrd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_in) begin
                r_cnt <= '0;
            end else if (o_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_READ;
            end
            S_READ:   n_state = S_ONSET;
            S_ONSET:  n_state = S_OFFSET;
            S_OFFSET: n_state = S_WRITE;
            S_WRITE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE) || !i_rst_n;
        unique case (r_state)
            S_IDLE:   o_cmd.load_in  = i_in_valid && i_rst_n;
            S_DIVIDE: o_cmd.div_step = 1'b1;
            S_READ:   o_cmd.read     = 1'b1;
            S_ONSET:  o_cmd.onset    = 1'b1;
            S_OFFSET: o_cmd.offset   = 1'b1;
            S_WRITE:  o_cmd.commit   = !i_stat.out_busy;
            default:  o_cmd          = '0;
        endcase
    end

    `NRD_ASSERT_NEXT(a_commit_to_idle, o_cmd.commit, r_state == S_IDLE)
    `NRD_ASSERT_NOW(a_single_cmd, 1'b1, $onehot0(o_cmd))

endmodule

@@ rtl/nrd_datapath.sv @@
// Datapath of the note record decoder: configuration, track selection divider,
// per-track state and the result register.
// Depends on nrd_pkg and note_record_decoder_defines.svh.
`include "note_record_decoder_defines.svh"
module nrd_datapath
    import nrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_track_byte,
    input  logic [BYTE_W-1:0]    i_interval_byte,
    input  logic [BYTE_W-1:0]    i_duration_byte,
    input  logic [BYTE_W-1:0]    i_pitch_byte,
    input  logic [BYTE_W-1:0]    i_velocity_byte,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_outcome,
    output logic [TRACK_W-1:0]   o_track,
    output logic [WORD_W-1:0]    o_note_index,
    output logic [WORD_W-1:0]    o_inter_onset,
    output logic [BYTE_W-1:0]    o_duration,
    output logic [WORD_W-1:0]    o_onset,
    output logic [WORD_W-1:0]    o_offset,
    output logic [BYTE_W-1:0]    o_pitch,
    output logic [BYTE_W-1:0]    o_velocity,
    output logic [WORD_W-1:0]    o_track_length,
    output logic [WORD_W-1:0]    o_overall_length,
    output logic                 o_onset_wrapped
);

    // configuration
    logic [NT_W-1:0]   r_num_tracks;
    logic              r_rests_en;
    logic              r_vel_en;
    logic [2:0]        r_omit_sel;
    logic [BYTE_W-1:0] r_imask, r_dmask, r_pmask, r_vmask;

    // captured request
    logic [BYTE_W-1:0] r_tb, r_ib, r_db, r_pb, r_vb;

    // divider
    logic [TRACK_W:0]  r_rem;
    logic [NT_W-1:0]   n_eff;
    logic [TRACK_W:0]  n_trial;
    logic [TRACK_W:0]  n_rem;
    logic [TRACK_W-1:0] w_trk;

    // per-track state
    logic [WORD_W-1:0] r_pend [MAX_TRACKS];
    logic [WORD_W-1:0] r_last [MAX_TRACKS];
    logic [WORD_W-1:0] r_tlen [MAX_TRACKS];
    logic [WORD_W-1:0] r_ncnt [MAX_TRACKS];
    logic [WORD_W-1:0] r_max;

    // working registers
    logic [1:0]        r_kind;
    logic [WORD_W-1:0] r_ioi, r_prev, r_len, r_idx, r_onset, r_offset, r_newlen;
    logic [WORD_W-1:0] n_offset, n_newlen, n_max;
    logic [BYTE_W-1:0] n_dur, n_pitch, n_vel, n_vmasked;
    logic              n_rest, n_omit;

    always_comb begin
        if (r_num_tracks == '0) begin
            n_eff = NT_W'(1);
        end else if (r_num_tracks > NT_W'(MAX_TRACKS)) begin
            n_eff = NT_W'(MAX_TRACKS);
        end else begin
            n_eff = r_num_tracks;
        end
        n_trial = {r_rem[TRACK_W-1:0], r_tb[BYTE_W-1]};
        n_rem   = ({1'b0, n_trial} >= {1'b0, n_eff}) ?
                  (TRACK_W+1)'({1'b0, n_trial} - {1'b0, n_eff}) : n_trial;
        w_trk   = r_rem[TRACK_W-1:0];

        n_dur     = r_db & r_dmask;
        n_pitch   = r_pb & r_pmask;
        n_vmasked = r_vb & r_vmask;
        n_vel     = r_vel_en ? n_vmasked : VEL_DEFAULT;
        n_rest    = r_rests_en && r_pb[BYTE_W-1] && (!r_vel_en || r_vb[BYTE_W-1]);
        n_omit    = (r_omit_sel[0] && (n_dur == '0)) ||
                    (r_omit_sel[1] && (n_pitch == '0)) ||
                    (r_vel_en && r_omit_sel[2] && (n_vmasked == '0));

        n_offset = r_onset + WORD_W'(n_dur);
        n_newlen = (r_len < n_offset) ? n_offset : r_len;
        n_max    = (r_max < r_newlen) ? r_newlen : r_max;

        o_stat.out_busy = o_out_valid && i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_tracks <= NT_W'(1);
            r_rests_en   <= 1'b0;
            r_vel_en     <= 1'b0;
            r_omit_sel   <= '0;
            r_imask      <= 8'd255;
            r_dmask      <= 8'd255;
            r_pmask      <= 8'd127;
            r_vmask      <= 8'd127;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_TRACKS:   r_num_tracks <= i_cfg_data[NT_W-1:0];
                CFG_RESTS_EN:     r_rests_en   <= i_cfg_data[0];
                CFG_VELOCITY_EN:  r_vel_en     <= i_cfg_data[0];
                CFG_OMIT_SEL:     r_omit_sel   <= i_cfg_data[2:0];
                CFG_INTERVAL_MSK: r_imask      <= i_cfg_data;
                CFG_DURATION_MSK: r_dmask      <= i_cfg_data;
                CFG_PITCH_MSK:    r_pmask      <= i_cfg_data;
                CFG_VELOCITY_MSK: r_vmask      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tb  <= i_track_byte;
            r_ib  <= i_interval_byte;
            r_db  <= i_duration_byte;
            r_pb  <= i_pitch_byte;
            r_vb  <= i_velocity_byte;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_tb  <= {r_tb[BYTE_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
        if (i_cmd.read) begin
            r_kind <= n_rest ? OUT_REST : (n_omit ? OUT_OMIT : OUT_NOTE);
            r_ioi  <= r_pend[w_trk] + WORD_W'(n_rest ? r_ib : (r_ib & r_imask));
            r_prev <= r_last[w_trk];
            r_len  <= r_tlen[w_trk];
            r_idx  <= r_ncnt[w_trk];
        end
        if (i_cmd.onset) begin
            r_onset <= r_prev + r_ioi;
        end
        if (i_cmd.offset) begin
            r_offset <= n_offset;
        end
        if (i_cmd.offset) begin
            r_newlen <= n_newlen;
        end
    end

    // track state and running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TRACKS; k++) begin
                r_pend[k] <= '0;
                r_last[k] <= '0;
                r_tlen[k] <= '0;
                r_ncnt[k] <= '0;
            end
            r_max <= '0;
        end else if (i_cmd.commit) begin
            unique case (r_kind)
                OUT_REST: r_pend[w_trk] <= r_ioi;
                OUT_NOTE: begin
                    r_pend[w_trk] <= '0;
                    r_last[w_trk] <= r_onset;
                    r_tlen[w_trk] <= r_newlen;
                    r_max         <= n_max;
                    if (r_idx != IDX_FULL) r_ncnt[w_trk] <= r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_outcome        <= r_kind;
            o_track          <= w_trk;
            o_note_index     <= '0;
            o_inter_onset    <= '0;
            o_duration       <= '0;
            o_onset          <= '0;
            o_offset         <= '0;
            o_pitch          <= '0;
            o_velocity       <= '0;
            o_track_length   <= '0;
            o_overall_length <= '0;
            o_onset_wrapped  <= 1'b0;
            if (r_kind == OUT_NOTE) begin
                o_note_index     <= r_idx;
                o_inter_onset    <= r_ioi;
                o_duration       <= n_dur;
                o_onset          <= r_onset;
                o_offset         <= r_offset;
                o_pitch          <= n_pitch;
                o_velocity       <= n_vel;
                o_track_length   <= r_newlen;
                o_overall_length <= n_max;
                o_onset_wrapped  <= (r_onset < r_prev);
            end
        end
    end

    `NRD_ASSERT_NOW(a_rem_in_range, i_cmd.read, {1'b0, r_rem} < {1'b0, n_eff})
    `NRD_ASSERT_NOW(a_valid_from_commit, $rose(o_out_valid), $past(i_cmd.commit))
    `NRD_ASSERT_NOW(a_no_commit_when_busy, i_cmd.commit, !(o_out_valid && i_out_stall))
    `NRD_ASSERT_NOW(a_blank_when_not_note,
        o_out_valid && (o_outcome != OUT_NOTE),
        (o_note_index == '0) && (o_overall_length == '0) && !o_onset_wrapped)

endmodule

@@ rtl/note_record_decoder.sv @@
// Top level of the note record decoder: controller and datapath.
// Depends on nrd_pkg, nrd_ctrl and nrd_datapath.
//
// Input channel: i_in_valid / o_in_stall with five record bytes. A request is
// taken when valid is high and stall is low. One record is decoded at a time.
// Output channel: o_out_valid / i_out_stall with one result per record.
// Configuration: i_cfg_valid / o_cfg_ready, register index and data; write only
// while no record is in flight.
// Sequence: after a request is taken, the track is chosen by a restoring
// divider that resolves one bit of the track byte per cycle, then the read,
// two adds and the write back of the per-track state follow; the result is
// registered at the write back, and only then is a new record taken.
// The result sits in an output register, so a new record is taken while the
// previous result waits; a stalled result holds the commit of the next one.
// Reset (synchronous, active low) clears all track state and loads the
// default configuration; both request channels are held off during reset.
module note_record_decoder
    import nrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_track_byte,
    input  logic [BYTE_W-1:0]    i_interval_byte,
    input  logic [BYTE_W-1:0]    i_duration_byte,
    input  logic [BYTE_W-1:0]    i_pitch_byte,
    input  logic [BYTE_W-1:0]    i_velocity_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_outcome,
    output logic [TRACK_W-1:0]   o_track,
    output logic [WORD_W-1:0]    o_note_index,
    output logic [WORD_W-1:0]    o_inter_onset,
    output logic [BYTE_W-1:0]    o_duration,
    output logic [WORD_W-1:0]    o_onset,
    output logic [WORD_W-1:0]    o_offset,
    output logic [BYTE_W-1:0]    o_pitch,
    output logic [BYTE_W-1:0]    o_velocity,
    output logic [WORD_W-1:0]    o_track_length,
    output logic [WORD_W-1:0]    o_overall_length,
    output logic                 o_onset_wrapped
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    nrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nrd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_track_byte     (i_track_byte),
        .i_interval_byte  (i_interval_byte),
        .i_duration_byte  (i_duration_byte),
        .i_pitch_byte     (i_pitch_byte),
        .i_velocity_byte  (i_velocity_byte),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_outcome        (o_outcome),
        .o_track          (o_track),
        .o_note_index     (o_note_index),
        .o_inter_onset    (o_inter_onset),
        .o_duration       (o_duration),
        .o_onset          (o_onset),
        .o_offset         (o_offset),
        .o_pitch          (o_pitch),
        .o_velocity       (o_velocity),
        .o_track_length   (o_track_length),
        .o_overall_length (o_overall_length),
        .o_onset_wrapped  (o_onset_wrapped)
    );

endmodule
